// File: hw/rtl/bsv_pkg.sv
// Shared constants, codes and controller/datapath interface types
// for the bounding sphere block. No dependencies.
package bsv_pkg;

    localparam int MAX_VERTICES = 4096;
    localparam int ADDR_W       = $clog2(MAX_VERTICES);
    localparam int CNT_W        = ADDR_W + 1;
    localparam int COORD_W      = 24;
    localparam int SUM_W        = COORD_W + ADDR_W;
    localparam int DIFF_W       = COORD_W + 1;
    localparam int SQ_W         = 2 * DIFF_W;
    localparam int D2_W         = SQ_W;
    localparam int RAD_W        = 25;
    localparam int DIV_STEPS    = SUM_W;
    localparam int DIV_CNT_W    = $clog2(DIV_STEPS);
    localparam int SQRT_STEPS   = D2_W / 2;
    localparam int SQRT_CNT_W   = $clog2(SQRT_STEPS);

    localparam logic [1:0] KIND_MIN = 2'd0;
    localparam logic [1:0] KIND_MAX = 2'd1;
    localparam logic [1:0] KIND_VTX = 2'd2;

    typedef struct packed {
        logic accept;
        logic div_init;
        logic div_step;
        logic scan_init;
        logic scan_box;
        logic sqrt_init;
        logic sqrt_step;
        logic emit;
        logic emit_empty;
    } cmd_t;

    typedef struct packed {
        logic count_zero;
        logic div_last;
        logic scan_done;
        logic sqrt_last;
    } sts_t;

endpackage

// File: hw/rtl/bounding_sphere_from_vertices.sv
// Top level of the bounding sphere block: controller plus datapath.
// Depends on bsv_pkg, bsv_ctrl, bsv_dp.
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------------
//  in       | start & !busy        | kind, x_coord, y_coord, z_coord, last_item
//  out      | result_valid (pulse) | center_x/y/z, radius, used_mean, empty_set
//
// Corner and vertex beats are accepted while idle; busy stays low between them.
// A beat with last_item raises busy; a non-empty set then runs a 36-step
// divider, two scans over the store at one read a cycle, and a 25-step sqrt.
// An empty set answers from the check state, with no divide, scan or sqrt.
// Reset clears sums, count and corners; the store holds no reset.
// Results are a one-cycle strobe; the receiver cannot stall them.
module bounding_sphere_from_vertices
    import bsv_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [1:0]                 kind,
    input  logic signed [COORD_W-1:0]  x_coord,
    input  logic signed [COORD_W-1:0]  y_coord,
    input  logic signed [COORD_W-1:0]  z_coord,
    input  logic                       last_item,
    output logic                       result_valid,
    output logic signed [COORD_W-1:0]  center_x,
    output logic signed [COORD_W-1:0]  center_y,
    output logic signed [COORD_W-1:0]  center_z,
    output logic [RAD_W-1:0]           radius,
    output logic                       used_mean,
    output logic                       empty_set
);

    cmd_t cmd;
    sts_t sts;

    bsv_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .last_item (last_item),
        .sts       (sts),
        .cmd       (cmd),
        .busy      (busy)
    );

    bsv_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .kind         (kind),
        .x_coord      (x_coord),
        .y_coord      (y_coord),
        .z_coord      (z_coord),
        .result_valid (result_valid),
        .center_x     (center_x),
        .center_y     (center_y),
        .center_z     (center_z),
        .radius       (radius),
        .used_mean    (used_mean),
        .empty_set    (empty_set)
    );

endmodule

// File: hw/rtl/bsv_ctrl.sv
// Sequencer for the bounding sphere block: load, divide, two scans, sqrt.
// Depends on bsv_pkg.
module bsv_ctrl
    import bsv_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  logic last_item,
    input  sts_t sts,
    output cmd_t cmd,
    output logic busy
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_CHECK  = 3'd1;
    localparam logic [2:0] ST_DIV    = 3'd2;
    localparam logic [2:0] ST_SCAN_M = 3'd3;
    localparam logic [2:0] ST_SCAN_B = 3'd4;
    localparam logic [2:0] ST_SQRT   = 3'd5;
    localparam logic [2:0] ST_FINISH = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign busy = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.accept = 1'b1;
                    if (last_item)
                        state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (sts.count_zero)
                begin
                    cmd.emit_empty = 1'b1;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    cmd.div_init = 1'b1;
                    state_next   = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    cmd.scan_init = 1'b1;
                    state_next    = ST_SCAN_M;
                end
            end
            ST_SCAN_M:
            begin
                if (sts.scan_done)
                begin
                    cmd.scan_init = 1'b1;
                    cmd.scan_box  = 1'b1;
                    state_next    = ST_SCAN_B;
                end
            end
            ST_SCAN_B:
            begin
                if (sts.scan_done)
                begin
                    cmd.sqrt_init = 1'b1;
                    state_next    = ST_SQRT;
                end
            end
            ST_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                if (sts.sqrt_last)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                cmd.emit   = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

`ifndef SYNTHESIS
    a_last_to_check: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && start && last_item) |=> (state_reg == ST_CHECK))
        else $error("last beat did not start evaluation");
    a_emit_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit || cmd.emit_empty) |=> (state_reg == ST_IDLE))
        else $error("not idle after result");
    a_div_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV && !sts.div_last) |=> (state_reg == ST_DIV))
        else $error("divide left early");
    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |-> !busy)
        else $error("beat taken while busy");
`endif

endmodule

// File: hw/rtl/bsv_dp.sv
// Datapath: vertex store, sums, corners, mean divider, distance scan and sqrt.
// Depends on bsv_pkg.
module bsv_dp
    import bsv_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  cmd_t                       cmd,
    output sts_t                       sts,
    input  logic [1:0]                 kind,
    input  logic signed [COORD_W-1:0]  x_coord,
    input  logic signed [COORD_W-1:0]  y_coord,
    input  logic signed [COORD_W-1:0]  z_coord,
    output logic                       result_valid,
    output logic signed [COORD_W-1:0]  center_x,
    output logic signed [COORD_W-1:0]  center_y,
    output logic signed [COORD_W-1:0]  center_z,
    output logic [RAD_W-1:0]           radius,
    output logic                       used_mean,
    output logic                       empty_set
);

    logic [3*COORD_W-1:0] mem [MAX_VERTICES];
    logic [3*COORD_W-1:0] rdata_reg;

    logic signed [SUM_W-1:0]   sum_reg   [3];
    logic signed [COORD_W-1:0] min_reg   [3];
    logic signed [COORD_W-1:0] max_reg   [3];
    logic signed [COORD_W-1:0] box_reg   [3];
    logic [CNT_W-1:0]          count_reg;

    logic [SUM_W-1:0]     dq_reg  [3];
    logic [CNT_W-1:0]     dr_reg  [3];
    logic                 neg_reg [3];
    logic [SUM_W-1:0]     dq_next [3];
    logic [CNT_W-1:0]     dr_next [3];
    logic [DIV_CNT_W-1:0] dcnt_reg;
    logic signed [COORD_W-1:0] mean_c [3];

    logic               sel_box_reg;
    logic               issue_reg;
    logic [CNT_W-1:0]   addr_reg;
    logic               v1_reg, l1_reg, v2_reg, l2_reg, first_reg, done_reg;
    logic [SQ_W-2:0]    sq_reg [3];
    logic [D2_W-1:0]    best_reg, dm_reg, db_reg;
    logic [D2_W-1:0]    d_c, best_c;

    logic [D2_W-1:0]       sv_reg, sres_reg, sbit_reg;
    logic [SQRT_CNT_W-1:0] scnt_reg;
    logic                  use_mean_reg;

    logic vtx_we;
    logic signed [COORD_W-1:0] in_c [3];

    assign in_c[0] = x_coord;
    assign in_c[1] = y_coord;
    assign in_c[2] = z_coord;
    assign vtx_we  = cmd.accept && (kind == KIND_VTX) && (count_reg < CNT_W'(MAX_VERTICES));

    assign sts.count_zero = (count_reg == '0);
    assign sts.div_last   = (dcnt_reg == DIV_CNT_W'(DIV_STEPS - 1));
    assign sts.scan_done  = done_reg;
    assign sts.sqrt_last  = (scnt_reg == SQRT_CNT_W'(SQRT_STEPS - 1));

    // vertex store, one write port and one registered read port
    always_ff @(posedge clk)
    begin
        if (vtx_we)
            mem[count_reg[ADDR_W-1:0]] <= {x_coord, y_coord, z_coord};
        rdata_reg <= mem[addr_reg[ADDR_W-1:0]];
    end

    // restoring divide, one quotient bit per axis per cycle
    always_comb
    begin
        logic [CNT_W:0] sh;
        for (int k = 0; k < 3; k++)
        begin
            sh = {dr_reg[k], dq_reg[k][SUM_W-1]};
            if (sh >= {1'b0, count_reg})
            begin
                dr_next[k] = CNT_W'(sh - {1'b0, count_reg});
                dq_next[k] = {dq_reg[k][SUM_W-2:0], 1'b1};
            end
            else
            begin
                dr_next[k] = sh[CNT_W-1:0];
                dq_next[k] = {dq_reg[k][SUM_W-2:0], 1'b0};
            end
            mean_c[k] = neg_reg[k] ? -$signed(dq_reg[k][COORD_W-1:0])
                                   : $signed(dq_reg[k][COORD_W-1:0]);
        end
    end

    // farthest-vertex compare: first vertex always taken, then strict greater
    assign d_c    = D2_W'(sq_reg[0]) + D2_W'(sq_reg[1]) + D2_W'(sq_reg[2]);
    assign best_c = (first_reg || d_c > best_reg) ? d_c : best_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 3; k++)
            begin
                sum_reg[k] <= '0;
                min_reg[k] <= '0;
                max_reg[k] <= '0;
            end
            count_reg    <= '0;
            dcnt_reg     <= '0;
            issue_reg    <= 1'b0;
            addr_reg     <= '0;
            v1_reg       <= 1'b0;
            l1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            l2_reg       <= 1'b0;
            first_reg    <= 1'b0;
            done_reg     <= 1'b0;
            sel_box_reg  <= 1'b0;
            scnt_reg     <= '0;
            result_valid <= 1'b0;
            empty_set    <= 1'b0;
            used_mean    <= 1'b0;
        end
        else
        begin
            result_valid <= 1'b0;
            done_reg     <= 1'b0;

            if (cmd.accept)
            begin
                case (kind)
                    KIND_MIN:
                    begin
                        for (int k = 0; k < 3; k++)
                            min_reg[k] <= in_c[k];
                    end
                    KIND_MAX:
                    begin
                        for (int k = 0; k < 3; k++)
                            max_reg[k] <= in_c[k];
                    end
                    KIND_VTX:
                    begin
                        if (vtx_we)
                        begin
                            for (int k = 0; k < 3; k++)
                                sum_reg[k] <= sum_reg[k] + SUM_W'(in_c[k]);
                            count_reg <= count_reg + 1'b1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end

            if (cmd.div_init)
                dcnt_reg <= '0;
            else if (cmd.div_step)
                dcnt_reg <= dcnt_reg + 1'b1;

            // scan pipeline: read, square, compare against the farthest so far
            if (cmd.scan_init)
            begin
                issue_reg   <= 1'b1;
                addr_reg    <= '0;
                first_reg   <= 1'b1;
                sel_box_reg <= cmd.scan_box;
            end
            else if (issue_reg)
            begin
                addr_reg <= addr_reg + 1'b1;
                if (addr_reg == count_reg - 1'b1)
                    issue_reg <= 1'b0;
            end
            v1_reg <= issue_reg && !cmd.scan_init;
            l1_reg <= (addr_reg == count_reg - 1'b1);
            v2_reg <= v1_reg;
            l2_reg <= l1_reg;
            if (v2_reg)
            begin
                first_reg <= 1'b0;
                if (l2_reg)
                    done_reg <= 1'b1;
            end

            if (cmd.sqrt_init)
                scnt_reg <= '0;
            else if (cmd.sqrt_step)
                scnt_reg <= scnt_reg + 1'b1;

            if (cmd.emit)
            begin
                result_valid <= 1'b1;
                empty_set    <= 1'b0;
                used_mean    <= use_mean_reg;
            end
            else if (cmd.emit_empty)
            begin
                result_valid <= 1'b1;
                empty_set    <= 1'b1;
                used_mean    <= 1'b0;
            end

            if (cmd.emit || cmd.emit_empty)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    sum_reg[k] <= '0;
                    min_reg[k] <= '0;
                    max_reg[k] <= '0;
                end
                count_reg <= '0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        logic signed [DIFF_W-1:0] ctr;
        logic signed [DIFF_W-1:0] pt;
        logic signed [DIFF_W-1:0] dd;
        logic signed [COORD_W:0]  bs;
        for (int k = 0; k < 3; k++)
        begin
            bs = DIFF_W'(max_reg[k]) + DIFF_W'(min_reg[k]);
            if (cmd.div_init)
            begin
                dq_reg[k]  <= sum_reg[k][SUM_W-1] ? SUM_W'(-sum_reg[k]) : sum_reg[k];
                neg_reg[k] <= sum_reg[k][SUM_W-1];
                dr_reg[k]  <= '0;
                box_reg[k] <= bs[COORD_W:1];
            end
            else if (cmd.div_step)
            begin
                dq_reg[k] <= dq_next[k];
                dr_reg[k] <= dr_next[k];
            end
            ctr = sel_box_reg ? DIFF_W'(box_reg[k]) : DIFF_W'(mean_c[k]);
            pt  = DIFF_W'($signed(rdata_reg[(2-k)*COORD_W +: COORD_W]));
            dd  = pt - ctr;
            sq_reg[k] <= (SQ_W-1)'(dd * dd);
        end

        if (v2_reg)
        begin
            best_reg <= best_c;
            if (l2_reg)
            begin
                if (sel_box_reg)
                    db_reg <= best_c;
                else
                    dm_reg <= best_c;
            end
        end

        // bitwise integer sqrt, two radicand bits per cycle
        if (cmd.sqrt_init)
        begin
            use_mean_reg <= (dm_reg < db_reg);
            sv_reg       <= (dm_reg < db_reg) ? dm_reg : db_reg;
            sres_reg     <= '0;
            sbit_reg     <= D2_W'(1) << (D2_W - 2);
        end
        else if (cmd.sqrt_step)
        begin
            if (sv_reg >= sres_reg + sbit_reg)
            begin
                sv_reg   <= sv_reg - (sres_reg + sbit_reg);
                sres_reg <= (sres_reg >> 1) + sbit_reg;
            end
            else
            begin
                sres_reg <= sres_reg >> 1;
            end
            sbit_reg <= sbit_reg >> 2;
        end

        if (cmd.emit)
        begin
            center_x <= use_mean_reg ? mean_c[0] : box_reg[0];
            center_y <= use_mean_reg ? mean_c[1] : box_reg[1];
            center_z <= use_mean_reg ? mean_c[2] : box_reg[2];
            radius   <= sres_reg[RAD_W-1:0];
        end
        else if (cmd.emit_empty)
        begin
            center_x <= '0;
            center_y <= '0;
            center_z <= '0;
            radius   <= '0;
        end
    end

`ifndef SYNTHESIS
    a_no_store_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_VERTICES))
        else $error("vertex count beyond store");
    a_done_from_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(v2_reg && l2_reg))
        else $error("scan done without final compare");
    a_empty_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && empty_set) |-> (radius == '0 && !used_mean))
        else $error("empty result carries data");
`endif

endmodule

// File: dv/tb.sv
// Self-checking bench for bounding_sphere_from_vertices: drives corner and
// vertex beats from a queue and checks each sphere against a local predictor.
// Depends on bsv_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb;
    import bsv_pkg::*;

    typedef struct {
        logic [1:0]         kind;
        logic signed [23:0] x;
        logic signed [23:0] y;
        logic signed [23:0] z;
        logic               last;
    } beat_t;

    typedef struct {
        logic signed [23:0] cx;
        logic signed [23:0] cy;
        logic signed [23:0] cz;
        logic [24:0]        rad;
        logic               mean;
        logic               empty;
    } sphere_t;

    logic clk = 1'b0;
    logic rst_n;
    logic start;
    logic busy;
    logic [1:0] kind;
    logic signed [23:0] x_coord, y_coord, z_coord;
    logic last_item;
    logic result_valid;
    logic signed [23:0] center_x, center_y, center_z;
    logic [24:0] radius;
    logic used_mean, empty_set;

    bounding_sphere_from_vertices dut (.*);

    beat_t   pending_beats[$];
    sphere_t expected_spheres[$];
    int      send_idle_pct;
    bit      hold_sender;
    int      fail_count = 0;
    longint  cycle_count = 0;

    // predictor state
    logic signed [23:0] pts[MAX_VERTICES][3];
    longint sums[3] = '{0, 0, 0};
    int     nverts = 0;
    logic signed [23:0] bmin[3] = '{0, 0, 0};
    logic signed [23:0] bmax[3] = '{0, 0, 0};

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic longint unsigned far_dist2(longint c0, longint c1, longint c2);
        longint unsigned best, d;
        longint a, b, e;
        best = 0;
        for (int i = 0; i < nverts; i++)
        begin
            a = pts[i][0] - c0;
            b = pts[i][1] - c1;
            e = pts[i][2] - c2;
            d = a * a + b * b + e * e;
            if (i == 0 || d > best)
                best = d;
        end
        return best;
    endfunction

    function automatic longint unsigned floor_sqrt(longint unsigned v);
        longint unsigned r, lo, hi, m;
        lo = 0;
        hi = 64'd4294967296;
        while (hi - lo > 1)
        begin
            m = (lo + hi) / 2;
            if (m * m <= v)
                lo = m;
            else
                hi = m;
        end
        r = lo;
        return r;
    endfunction

    task automatic predict_beat(beat_t b);
        sphere_t s;
        longint mn[3], bx[3], t;
        longint unsigned dm, db;
        if (b.kind == KIND_MIN)
        begin
            bmin[0] = b.x; bmin[1] = b.y; bmin[2] = b.z;
        end
        else if (b.kind == KIND_MAX)
        begin
            bmax[0] = b.x; bmax[1] = b.y; bmax[2] = b.z;
        end
        else if (b.kind == KIND_VTX && nverts < MAX_VERTICES)
        begin
            pts[nverts][0] = b.x; pts[nverts][1] = b.y; pts[nverts][2] = b.z;
            sums[0] += b.x; sums[1] += b.y; sums[2] += b.z;
            nverts++;
        end
        if (!b.last)
            return;
        s = '{0, 0, 0, 0, 0, 0};
        if (nverts == 0)
            s.empty = 1'b1;
        else
        begin
            for (int k = 0; k < 3; k++)
            begin
                mn[k] = sums[k] / nverts; // SV division truncates toward zero
                t = longint'(bmax[k]) + longint'(bmin[k]);
                bx[k] = t >>> 1;
            end
            dm = far_dist2(mn[0], mn[1], mn[2]);
            db = far_dist2(bx[0], bx[1], bx[2]);
            s.mean = dm < db;
            s.cx = 24'(s.mean ? mn[0] : bx[0]);
            s.cy = 24'(s.mean ? mn[1] : bx[1]);
            s.cz = 24'(s.mean ? mn[2] : bx[2]);
            s.rad = 25'(floor_sqrt(s.mean ? dm : db));
        end
        expected_spheres.push_back(s);
        sums = '{0, 0, 0};
        nverts = 0;
        bmin = '{0, 0, 0};
        bmax = '{0, 0, 0};
    endtask

    function automatic logic signed [23:0] rand_coord(int mode);
        case (mode)
            0: return 24'($urandom);
            1: return $signed(24'($urandom_range(0, 2000))) - 24'sd1000;
            2: return ($urandom & 1) ? 24'sh7FFFFF : 24'sh800000;
            default: return $signed(24'($urandom_range(0, 200000))) - 24'sd100000;
        endcase
    endfunction

    function automatic beat_t mk(logic [1:0] k, int mode, logic l);
        beat_t b;
        b.kind = k;
        b.x = rand_coord(mode);
        b.y = rand_coord(mode);
        b.z = rand_coord(mode);
        b.last = l;
        return b;
    endfunction

    // a set: corners then vertices, last flag on the final beat (an empty set also flags its min corner)
    task automatic queue_set(int nv, int mode);
        pending_beats.push_back(mk(KIND_MIN, mode, nv == 0));
        if (nv > 0 || $urandom_range(0, 1))
            pending_beats.push_back(mk(KIND_MAX, mode, nv == 0 && 1'b0));
        for (int i = 0; i < nv; i++)
            pending_beats.push_back(mk(KIND_VTX, mode, i == nv - 1));
        if (nv == 0)
            pending_beats.push_back(mk(KIND_MAX, mode, 1'b1));
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start     <= 1'b0;
            kind      <= '0;
            x_coord   <= '0;
            y_coord   <= '0;
            z_coord   <= '0;
            last_item <= 1'b0;
        end
        else if (!start || !busy)
        begin
            if (start)
                predict_beat('{kind, x_coord, y_coord, z_coord, last_item});
            if (pending_beats.size() > 0 && !hold_sender &&
                $urandom_range(0, 99) >= send_idle_pct)
            begin
                beat_t b;
                b = pending_beats.pop_front();
                start     <= 1'b1;
                kind      <= b.kind;
                x_coord   <= b.x;
                y_coord   <= b.y;
                z_coord   <= b.z;
                last_item <= b.last;
            end
            else
                start <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            if (expected_spheres.size() == 0)
            begin
                $display("%0t: unexpected result centre %0d %0d %0d radius %0d",
                         $time, center_x, center_y, center_z, radius);
                fail_count++;
            end
            else
            begin
                sphere_t e;
                e = expected_spheres.pop_front();
                if ({center_x, center_y, center_z, radius, used_mean, empty_set} !==
                    {e.cx, e.cy, e.cz, e.rad, e.mean, e.empty})
                begin
                    $display("%0t: expected c=(%0d,%0d,%0d) r=%0d mean=%0b empty=%0b",
                             $time, e.cx, e.cy, e.cz, e.rad, e.mean, e.empty);
                    $display("%0t: actual   c=(%0d,%0d,%0d) r=%0d mean=%0b empty=%0b",
                             $time, center_x, center_y, center_z, radius,
                             used_mean, empty_set);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > 64'd3000000)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic drain();
        while (pending_beats.size() > 0 || start || expected_spheres.size() > 0)
            @(posedge clk);
    endtask

    initial
    begin
        beat_t b;
        int nv;
        send_idle_pct = 0;
        hold_sender = 0;
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty set, extremes, unused kind, repeated corner
        pending_beats.push_back('{KIND_VTX, 0, 0, 0, 1'b0});
        pending_beats.push_back('{2'd3, 0, 0, 0, 1'b1});
        pending_beats.push_back('{2'd3, 24'sh7FFFFF, 24'sh800000, 0, 1'b1});
        pending_beats.push_back('{KIND_MIN, 24'sh800000, 24'sh800000, 24'sh800000, 1'b0});
        pending_beats.push_back('{KIND_MAX, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 1'b0});
        pending_beats.push_back('{KIND_VTX, 24'sh800000, 24'sh800000, 24'sh800000, 1'b0});
        pending_beats.push_back('{KIND_VTX, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 1'b1});
        pending_beats.push_back('{KIND_MIN, 5, 5, 5, 1'b0});
        pending_beats.push_back('{KIND_MIN, -7, 3, -1, 1'b0});
        pending_beats.push_back('{KIND_MAX, 4, 8, -2, 1'b0});
        pending_beats.push_back('{KIND_VTX, -3, 1, 2, 1'b0});
        pending_beats.push_back('{KIND_VTX, 2, -5, -4, 1'b0});
        pending_beats.push_back('{KIND_VTX, -1, 2, 1, 1'b0});
        pending_beats.push_back('{KIND_MAX, 4, 8, -2, 1'b1});
        pending_beats.push_back('{KIND_VTX, 24'sh800000, 24'sh7FFFFF, 24'sh800000, 1'b1});
        pending_beats.push_back('{KIND_MIN, 24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF, 1'b1});
        drain();

        // hold the sender idle; drain has already waited for every expected result
        hold_sender = 1;
        repeat (100) @(posedge clk);
        hold_sender = 0;

        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct = (ph == 1) ? 69 : (ph == 3 ? 7 : 0);
            for (int s = 0; s < 50; s++)
            begin
                nv = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12);
                if ($urandom_range(0, 9) == 0)
                begin
                    // noise: stray beats, unused kind, extra corners
                    repeat ($urandom_range(1, 4))
                    begin
                        b = mk(2'($urandom_range(0, 3)), $urandom_range(0, 3), 1'b0);
                        pending_beats.push_back(b);
                    end
                end
                queue_set(nv, $urandom_range(0, 3));
            end
            drain();
        end

        repeat (200) @(posedge clk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

// File: filelist.f
hw/rtl/bsv_pkg.sv
hw/rtl/bsv_ctrl.sv
hw/rtl/bsv_dp.sv
hw/rtl/bounding_sphere_from_vertices.sv
dv/tb.sv
